### rtl/n2a_fmt_pkg.sv
package n2a_fmt_pkg;

    // Format selector codes carried on the input tuser.
    typedef enum logic [2:0] {
        ACT_HEX8   = 3'd0,
        ACT_HEX16  = 3'd1,
        ACT_HEX32  = 3'd2,
        ACT_UDEC8  = 3'd3,
        ACT_SDEC8  = 3'd4,
        ACT_UDEC16 = 3'd5,
        ACT_SDEC16 = 3'd6
    } t_action;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 3;
    localparam int CHAR_W   = 8;
    localparam int MAG_W    = 16;
    localparam int MAX_CHARS = 8;
    localparam int CNT_W    = 4;
    localparam int PROD_W   = 33;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_HEX_OFS = 8'h37;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;

    // Reciprocals for constant division of a 16-bit magnitude:
    // floor(v / d) == (v * K) >> S for every v below 2^16.
    localparam logic [16:0] RECIP_10    = 17'd52429;
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam logic [16:0] RECIP_10000 = 17'd107375;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] n;
        n = {4'b0, nib};
        return (nib > 4'd9) ? (n + ASCII_HEX_OFS) : (n + ASCII_ZERO);
    endfunction

    function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] d);
        return {4'b0, d} + ASCII_ZERO;
    endfunction

endpackage

### rtl/number_to_ascii_formatter.sv
// Channel   Dir  tdata                       tuser          tlast
// s_axis    in   [31:0] value                [2:0] action   -
// m_axis    out  [7:0] character             -              last character of the number
//
// An input number yields 2, 4 or 8 characters in hex modes and 1 to 6 in decimal
// modes; the output serializer sends one character per cycle while the receiver is
// ready (action 7 yields no output). The accepting edge loads the input register;
// the number then moves through the quotient register into the serializer, and a
// busy later stage can hold it in either register. Reset is synchronous and empties
// all stages. A stalled output holds its character; the two front stages keep filling
// meanwhile.
module number_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tlast
);
    import n2a_fmt_pkg::*;

    // Input register
    logic                  r_s0_vld;
    logic [VALUE_W-1:0]    r_s0_val;
    logic [ACTION_W-1:0]   r_s0_act;

    // Quotient register
    logic                  r_s1_vld;
    logic [VALUE_W-1:0]    r_s1_val;
    logic [ACTION_W-1:0]   r_s1_act;
    logic                  r_s1_neg;
    logic [MAG_W-1:0]      r_s1_mag;
    logic [12:0]           r_s1_q1;
    logic [9:0]            r_s1_q2;
    logic [6:0]            r_s1_q3;
    logic [2:0]            r_s1_q4;

    // Serializer
    logic [CHAR_W*MAX_CHARS-1:0] r_seq;
    logic [CNT_W-1:0]            r_left;

    logic ser_free, ld, s1_rdy, s0_adv;

    // Stage 1 combinational
    logic                  n_neg;
    logic [MAG_W-1:0]      n_mag;
    logic [PROD_W-1:0]     p10, p100, p1000, p10000;

    // Load combinational
    logic [MAG_W-1:0]      t0;
    logic [12:0]           t1;
    logic [9:0]            t2;
    logic [6:0]            t3;
    logic [3:0]            d0, d1, d2, d3, d4;
    logic [2:0]            nd;
    logic [39:0]           dv, dl, dseq;
    logic [VALUE_W-1:0]    hv;
    logic [CHAR_W*MAX_CHARS-1:0] hseq, n_seq;
    logic [CNT_W-1:0]      n_cnt;

    assign ser_free = (r_left == '0) || (i_m_axis_tready && (r_left == CNT_W'(1)));
    assign ld       = r_s1_vld && ser_free;
    assign s1_rdy   = !r_s1_vld || ser_free;
    assign s0_adv   = r_s0_vld && s1_rdy;
    assign o_s_axis_tready = !r_s0_vld || s1_rdy;

    assign o_m_axis_tvalid = (r_left != '0);
    assign o_m_axis_tdata  = r_seq[CHAR_W-1:0];
    assign o_m_axis_tlast  = (r_left == CNT_W'(1));

    // Sign handling: two's complement negation within the field width, so the
    // most negative value maps onto its own bit pattern, which is the right magnitude.
    always_comb begin
        n_neg = 1'b0;
        n_mag = r_s0_val[MAG_W-1:0];
        case (r_s0_act)
            ACT_UDEC8: begin
                n_mag = {8'b0, r_s0_val[7:0]};
            end
            ACT_SDEC8: begin
                n_neg = r_s0_val[7];
                n_mag = {8'b0, (r_s0_val[7] ? (8'd0 - r_s0_val[7:0]) : r_s0_val[7:0])};
            end
            ACT_SDEC16: begin
                n_neg = r_s0_val[15];
                n_mag = r_s0_val[15] ? (16'd0 - r_s0_val[15:0]) : r_s0_val[15:0];
            end
            default: begin
                n_mag = r_s0_val[MAG_W-1:0];
            end
        endcase
    end

    assign p10    = PROD_W'(n_mag) * PROD_W'(RECIP_10);
    assign p100   = PROD_W'(n_mag) * PROD_W'(RECIP_100);
    assign p1000  = PROD_W'(n_mag) * PROD_W'(RECIP_1000);
    assign p10000 = PROD_W'(n_mag) * PROD_W'(RECIP_10000);

    // Digits from neighboring quotients: d_k = q_k - 10 * q_(k+1).
    always_comb begin
        t0 = r_s1_mag - ({r_s1_q1, 3'b0} + {2'b0, r_s1_q1, 1'b0});
        t1 = r_s1_q1 - ({r_s1_q2, 3'b0} + {2'b0, r_s1_q2, 1'b0});
        t2 = r_s1_q2 - ({r_s1_q3, 3'b0} + {2'b0, r_s1_q3, 1'b0});
        t3 = r_s1_q3 - ({1'b0, r_s1_q4, 3'b0} + {3'b0, r_s1_q4, 1'b0});
        d0 = t0[3:0];
        d1 = t1[3:0];
        d2 = t2[3:0];
        d3 = t3[3:0];
        d4 = {1'b0, r_s1_q4};

        if (d4 != '0)      nd = 3'd5;
        else if (d3 != '0) nd = 3'd4;
        else if (d2 != '0) nd = 3'd3;
        else if (d1 != '0) nd = 3'd2;
        else               nd = 3'd1;

        dv = {dec_char(d4), dec_char(d3), dec_char(d2), dec_char(d1), dec_char(d0)};
        // Left-align so the first printed digit sits in the top byte.
        case (nd)
            3'd1:    dl = dv << 32;
            3'd2:    dl = dv << 24;
            3'd3:    dl = dv << 16;
            3'd4:    dl = dv << 8;
            default: dl = dv;
        endcase
        for (int i = 0; i < 5; i++) begin
            dseq[8*i +: 8] = dl[39-8*i -: 8];
        end

        case (r_s1_act)
            ACT_HEX8:  hv = {r_s1_val[7:0], 24'b0};
            ACT_HEX16: hv = {r_s1_val[15:0], 16'b0};
            default:   hv = r_s1_val;
        endcase
        for (int i = 0; i < MAX_CHARS; i++) begin
            hseq[8*i +: 8] = hex_char(hv[31-4*i -: 4]);
        end

        n_seq = hseq;
        n_cnt = '0;
        case (r_s1_act)
            ACT_HEX8:  n_cnt = CNT_W'(2);
            ACT_HEX16: n_cnt = CNT_W'(4);
            ACT_HEX32: n_cnt = CNT_W'(8);
            ACT_UDEC8, ACT_SDEC8, ACT_UDEC16, ACT_SDEC16: begin
                n_seq = r_s1_neg ? {16'b0, dseq, ASCII_MINUS} : {24'b0, dseq};
                n_cnt = CNT_W'(nd) + CNT_W'(r_s1_neg);
            end
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_left   <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_s0_vld <= i_s_axis_tvalid;
            end
            if (s1_rdy) begin
                r_s1_vld <= r_s0_vld;
            end
            if (ld) begin
                r_left <= n_cnt;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s0_val <= i_s_axis_tdata;
            r_s0_act <= i_s_axis_tuser;
        end
        if (s0_adv) begin
            r_s1_val <= r_s0_val;
            r_s1_act <= r_s0_act;
            r_s1_neg <= n_neg;
            r_s1_mag <= n_mag;
            r_s1_q1  <= p10[31:19];
            r_s1_q2  <= p100[32:23];
            r_s1_q3  <= p1000[32:26];
            r_s1_q4  <= p10000[32:30];
        end
        if (ld) begin
            r_seq <= n_seq;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_seq <= r_seq >> CHAR_W;
        end
    end

endmodule

### rtl/n2a_fmt_chk.sv
module n2a_fmt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import n2a_fmt_pkg::*;

    logic legal_char;
    assign legal_char = (o_m_axis_tdata >= ASCII_ZERO && o_m_axis_tdata <= 8'h39)
                     || (o_m_axis_tdata >= 8'h41 && o_m_axis_tdata <= 8'h46)
                     || (o_m_axis_tdata == ASCII_MINUS);

    // The output is empty in the cycle after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> legal_char)
        else $error("character outside digit, A-F and minus");

    // A minus sign is always followed by at least one digit.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == ASCII_MINUS) |-> !o_m_axis_tlast)
        else $error("minus sign marked as last character");

endmodule

bind number_to_ascii_formatter n2a_fmt_chk u_n2a_fmt_chk (.*);

### test/number_to_ascii_formatter_test.sv
module number_to_ascii_formatter_test;
    import n2a_fmt_pkg::*;

    // Selector code outside the package enum; the block drops such a number.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;

    localparam int CLK_PERIOD   = 12;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT    = 400000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [VALUE_W-1:0]  s_value = '0;
    logic [ACTION_W-1:0] s_action = '0;
    logic                m_ready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [CHAR_W-1:0]   o_m_axis_tdata;
    logic                o_m_axis_tlast;

    t_char_exp exp_chars[$];
    int        err_count = 0;
    bit        tx_idle = 1'b1;
    bit        rx_idle = 1'b1;
    int        hold_request = 0;

    number_to_ascii_formatter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_value),   // [31:0] value
        .i_s_axis_tuser  (s_action),  // [2:0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] character
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    initial begin
        #(CLK_PERIOD * RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void push_char(input logic [CHAR_W-1:0] ch);
        t_char_exp e;
        e.ch   = ch;
        e.last = 1'b0;
        exp_chars.push_back(e);
    endfunction

    function automatic int push_hex(input logic [VALUE_W-1:0] v, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = v[4*i +: 4];
            push_char((nib > 4'd9) ? CHR_A + {4'b0, nib} - 8'd10 : CHR_ZERO + {4'b0, nib});
        end
        return digits;
    endfunction

    // Leading zeros are dropped, but the units digit always goes out.
    function automatic int push_decimal(input int unsigned mag);
        int unsigned weight[4] = '{10000, 1000, 100, 10};
        int unsigned rest;
        int unsigned d;
        bit          started;
        int          n;
        rest    = mag;
        started = 1'b0;
        n       = 0;
        for (int i = 0; i < 4; i++) begin
            d    = rest / weight[i];
            rest = rest - d * weight[i];
            if (started || d != 0) begin
                push_char(CHR_ZERO + d[7:0]);
                started = 1'b1;
                n++;
            end
        end
        push_char(CHR_ZERO + rest[7:0]);
        return n + 1;
    endfunction

    function automatic void predict_chars(input logic [VALUE_W-1:0] v,
                                          input logic [ACTION_W-1:0] a);
        int count;
        count = 0;
        case (a)
            ACT_HEX8:   count = push_hex({24'b0, v[7:0]}, 2);
            ACT_HEX16:  count = push_hex({16'b0, v[15:0]}, 4);
            ACT_HEX32:  count = push_hex(v, 8);
            ACT_UDEC8:  count = push_decimal({24'b0, v[7:0]});
            ACT_UDEC16: count = push_decimal({16'b0, v[15:0]});
            ACT_SDEC8: begin
                if (v[7]) begin
                    push_char(CHR_MINUS);
                    count = 1 + push_decimal(32'd256 - {24'b0, v[7:0]});
                end else begin
                    count = push_decimal({24'b0, v[7:0]});
                end
            end
            ACT_SDEC16: begin
                if (v[15]) begin
                    push_char(CHR_MINUS);
                    count = 1 + push_decimal(32'd65536 - {16'b0, v[15:0]});
                end else begin
                    count = push_decimal({16'b0, v[15:0]});
                end
            end
            default: count = 0;
        endcase
        if (count > 0) begin
            exp_chars[exp_chars.size() - 1].last = 1'b1;
        end
    endfunction

    // Called at a rising edge; returns at the edge where the transaction completes.
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [ACTION_W-1:0] a);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_valid  <= 1'b1;
        s_value  <= v;
        s_action <= a;
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        predict_chars(v, a);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[15:0] = 16'($urandom_range(0, 20));
            1: v[7:0]  = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            2: v[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            3: v[15:0] = 16'hFFFF - 16'($urandom_range(0, 20));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [ACTION_W-1:0] rand_action();
        if ($urandom_range(0, 15) == 0) begin
            return ACT_UNUSED;
        end
        return ACTION_W'($urandom_range(0, 6));
    endfunction

    // Receiver: random short holds, or a long hold when one is requested.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                n = hold_request;
                hold_request = 0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 5);
            end else begin
                m_ready <= 1'b1;
                n = 1;
            end
            repeat (n - 1) @(posedge i_clk);
        end
    end

    // Output values at the falling edge are the ones seen at the next rising edge.
    initial begin
        t_char_exp want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_ready) begin
                if (exp_chars.size() == 0) begin
                    if (err_count < 10) begin
                        $display("unexpected character: got %h last %b",
                                 o_m_axis_tdata, o_m_axis_tlast);
                    end
                    err_count++;
                end else begin
                    want = exp_chars.pop_front();
                    if (o_m_axis_tdata !== want.ch || o_m_axis_tlast !== want.last) begin
                        if (err_count < 10) begin
                            $display("character mismatch: expected %h last %b, got %h last %b",
                                     want.ch, want.last, o_m_axis_tdata, o_m_axis_tlast);
                        end
                        err_count++;
                    end
                end
            end
        end
    end

    task automatic test_hex_formats();
        send_number(32'hABCDEF00, ACT_HEX8);
        send_number(32'h000000FF, ACT_HEX8);
        send_number(32'hFFFF0000, ACT_HEX16);
        send_number(32'h0000FFFF, ACT_HEX16);
        send_number(32'h00000000, ACT_HEX32);
        send_number(32'hFFFFFFFF, ACT_HEX32);
        send_number(32'h89ABCDEF, ACT_HEX32);
    endtask

    task automatic test_decimal_formats();
        send_number(32'hFFFFFF00, ACT_UDEC8);
        send_number(32'h000000FF, ACT_UDEC8);
        send_number(32'h00000009, ACT_UDEC8);
        send_number(32'h00000064, ACT_UDEC8);
        send_number(32'h0000007F, ACT_SDEC8);
        send_number(32'h00000080, ACT_SDEC8);
        send_number(32'hFFFFFFFF, ACT_SDEC8);
        send_number(32'hFFFF0000, ACT_UDEC16);
        send_number(32'h0000FFFF, ACT_UDEC16);
        send_number(32'h00002710, ACT_UDEC16);
        send_number(32'h00007FFF, ACT_SDEC16);
        send_number(32'hFFFF8000, ACT_SDEC16);
        send_number(32'h0000FFFF, ACT_SDEC16);
    endtask

    task automatic test_unused_selector();
        send_number(32'hFFFFFFFF, ACT_UNUSED);
        send_number(32'h00000000, ACT_UNUSED);
    endtask

    task automatic test_random_mix();
        repeat (240) send_number(rand_value(), rand_action());
    endtask

    // The receiver stops for a long stretch while numbers keep coming,
    // so the pipeline fills and input transactions stall.
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        hold_request = 80;
        repeat (30) send_number(rand_value(), rand_action());
        tx_idle = 1'b1;
    endtask

    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (40) send_number(rand_value(), rand_action());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hex_formats();
        test_decimal_formats();
        test_unused_selector();
        test_random_mix();
        test_output_backpressure();
        test_full_rate();
        s_valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && exp_chars.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/n2a_fmt_pkg.sv
rtl/number_to_ascii_formatter.sv
rtl/n2a_fmt_chk.sv
test/number_to_ascii_formatter_test.sv
